// ===== hw/rtl/hbp_pkg.sv =====
// Shared types and constants for the Huffman bit packer.
// No dependencies; the interfaces and the top level import it.
package hbp_pkg;

   // fixed field widths of the channels
   localparam int KIND_W      = 2;
   localparam int SYM_FIELD_W = 8;
   localparam int WORD_BITS   = 16;
   localparam int LEN_FIELD_W = 5;
   localparam int BYTE_BITS   = 8;
   localparam int PAD_W       = 3;

   // table size default and the longest code the table accepts
   localparam int SYMBOL_COUNT_DEF = 256;
   localparam int MAX_CODE_LEN     = 16;
   localparam int LEN_LIMIT        = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;

   // result queue depth and its counter width
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   // one table entry: code length and code bits, bit 0 sent first
   typedef struct packed {
      logic [LEN_FIELD_W-1:0] len;
      logic [WORD_BITS-1:0]   code;
   } entry_type;

   // one result word
   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic [PAD_W-1:0]     pad_bits;
      logic                 last_of_run;
      logic                 final_byte;
   } rsp_type;

endpackage

// ===== hw/rtl/hbp_if.sv =====
// Valid/ready channel interfaces for the Huffman bit packer.
// Depends on hbp_pkg for the field widths.
interface hbp_req_if;
   import hbp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [SYM_FIELD_W-1:0] symbol;
   logic [WORD_BITS-1:0]   code_word;
   logic [LEN_FIELD_W-1:0] code_length;

   modport source (output valid, kind, symbol, code_word, code_length, input ready);
   modport sink   (input valid, kind, symbol, code_word, code_length, output ready);
endinterface

interface hbp_rsp_if;
   import hbp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] out_byte;
   logic [PAD_W-1:0]     pad_bits;
   logic                 last_of_run;
   logic                 final_byte;

   modport source (output valid, out_byte, pad_bits, last_of_run, final_byte, input ready);
   modport sink   (input valid, out_byte, pad_bits, last_of_run, final_byte, output ready);
endinterface

// ===== hw/rtl/huffman_bit_packer.sv =====
// Huffman bit packer for byte symbols: code table memory, bit merge, result queue.
// Depends on hbp_pkg and the channel interfaces in hbp_if.sv.
//
// Usage:
//   req_chan carries load, encode and flush words. A load writes one symbol's
//   code and length into the table unless the length exceeds LEN_LIMIT; an encode
//   appends the symbol's code, bit 0 first, to a byte filled from its MSB; a flush
//   sends the partial byte zero padded, with the pad count, and clears the packer.
//   rsp_chan carries one packed byte per word; last_of_run marks the last
//   byte caused by an input word, final_byte marks the padded flush byte.
// Throughput: one input word per cycle while req_chan.ready is high. An encode
//   yields zero, one or two bytes and the result channel moves one byte per
//   cycle while rsp_chan.ready is high, so a run of long codes is paced by the output side.
// Path: the table read and the word's control are registered at the accepting edge;
//   the merge stage then pushes the bytes into the queue, which drives rsp_chan.
// Stalls: bytes wait in an 8-entry queue; req_chan.ready drops when the
//   queue could not take the worst case of the words already in flight.
// Reset: clears the packer, the queue and the per-entry valid bits of the
//   table; an entry never loaded reads as length zero.
module huffman_bit_packer #(
   parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
   input  logic   clock,
   input  logic   reset,
   hbp_req_if.sink   req_chan,
   hbp_rsp_if.source rsp_chan
);
   import hbp_pkg::*;

   localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int ACC_W = BYTE_BITS + WORD_BITS;

   // code table memory and per-entry valid bits
   entry_type          table_mem [SYMBOL_COUNT];
   logic               entry_vld_ff [SYMBOL_COUNT];

   // stage 1: registered table read and the item that caused it
   entry_type          rd_entry_ff;
   logic               rd_vld_ff;
   logic               s1_valid_ff;
   logic [KIND_W-1:0]  s1_kind_ff;
   logic               s1_in_range_ff;

   // packer state
   logic [BYTE_BITS-1:0] partial_ff, partial_in;
   logic [PAD_W-1:0]     fill_ff, fill_in;

   // result queue
   rsp_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   cnt_ff;

   logic                 req_take;
   logic                 rsp_take;
   logic [SYM_W-1:0]     req_idx;
   logic                 req_in_range;
   logic                 load_we;
   logic [QCNT_W+1:0]    reserve;

   logic [LEN_FIELD_W-1:0] eff_len;
   logic [WORD_BITS-1:0]   len_mask;
   logic [WORD_BITS-1:0]   code_masked;
   logic [WORD_BITS-1:0]   code_rev;
   logic [ACC_W-1:0]       acc;
   logic [LEN_FIELD_W-1:0] total;
   logic [1:0]             push_n;
   rsp_type                push0, push1;

   // accept a word while the queue can absorb everything in flight
   assign reserve      = (QCNT_W+2)'(cnt_ff) + (s1_valid_ff ? (QCNT_W+2)'(2) : '0);
   assign req_chan.ready = (reserve <= (QCNT_W+2)'(QUEUE_DEPTH - 2));
   assign req_take     = req_chan.valid && req_chan.ready;
   assign rsp_take     = rsp_chan.valid && rsp_chan.ready;

   assign req_idx      = req_chan.symbol[SYM_W-1:0];
   assign req_in_range = ({1'b0, req_chan.symbol} < (SYM_FIELD_W+1)'(SYMBOL_COUNT));
   assign load_we      = req_take && (req_chan.kind == KIND_LOAD) && req_in_range
                         && (req_chan.code_length <= LEN_FIELD_W'(LEN_LIMIT));

   // write the table on a load, read it for every word
   always_ff @(posedge clock) begin
      if (load_we) begin
         table_mem[req_idx] <= '{len: req_chan.code_length, code: req_chan.code_word};
      end
      rd_entry_ff <= table_mem[req_idx];
   end

   // hold valid bits and the stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            entry_vld_ff[i] <= 1'b0;
         end
         rd_vld_ff      <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s1_kind_ff     <= KIND_LOAD;
         s1_in_range_ff <= 1'b0;
      end else begin
         if (load_we) begin
            entry_vld_ff[req_idx] <= 1'b1;
         end
         rd_vld_ff      <= entry_vld_ff[req_idx];
         s1_valid_ff    <= req_take;
         s1_kind_ff     <= req_chan.kind;
         s1_in_range_ff <= req_in_range;
      end
   end

   // merge the code into the partial byte and pick the finished bytes
   always_comb begin
      eff_len     = (rd_vld_ff && s1_in_range_ff) ? rd_entry_ff.len : '0;
      len_mask    = WORD_BITS'(((WORD_BITS+1)'(1) << eff_len) - (WORD_BITS+1)'(1));
      code_masked = rd_entry_ff.code & len_mask;
      for (int j = 0; j < WORD_BITS; j++) begin
         code_rev[WORD_BITS-1-j] = code_masked[j];
      end
      acc   = {partial_ff, {WORD_BITS{1'b0}}} | ({code_rev, {BYTE_BITS{1'b0}}} >> fill_ff);
      total = LEN_FIELD_W'(fill_ff) + eff_len;

      partial_in = partial_ff;
      fill_in    = fill_ff;
      push_n     = 2'd0;
      push0      = '{out_byte: acc[ACC_W-1 -: BYTE_BITS], pad_bits: '0,
                     last_of_run: 1'b1, final_byte: 1'b0};
      push1      = '{out_byte: acc[ACC_W-BYTE_BITS-1 -: BYTE_BITS], pad_bits: '0,
                     last_of_run: 1'b1, final_byte: 1'b0};

      if (s1_valid_ff) begin
         unique case (s1_kind_ff)
            KIND_ENCODE: begin
               push_n  = total[LEN_FIELD_W-1:PAD_W];
               fill_in = total[PAD_W-1:0];
               case (push_n)
                  2'd0:    partial_in = acc[ACC_W-1 -: BYTE_BITS];
                  2'd1:    partial_in = acc[ACC_W-BYTE_BITS-1 -: BYTE_BITS];
                  default: begin
                     partial_in        = acc[BYTE_BITS-1:0];
                     push0.last_of_run = 1'b0;
                  end
               endcase
            end
            KIND_FLUSH: begin
               if (fill_ff != '0) begin
                  push_n = 2'd1;
                  push0  = '{out_byte: partial_ff, pad_bits: PAD_W'(0) - fill_ff,
                             last_of_run: 1'b1, final_byte: 1'b1};
               end
               partial_in = '0;
               fill_in    = '0;
            end
            default: ;
         endcase
      end
   end

   // advance the packer state
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff    <= '0;
      end else begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
      end
   end

   // push up to two bytes, pop one
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPTR_W'(push_n);
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         cnt_ff <= cnt_ff + QCNT_W'(push_n) - QCNT_W'(rsp_take);
      end
   end

   assign rsp_chan.valid       = (cnt_ff != '0);
   assign rsp_chan.out_byte    = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_chan.pad_bits    = queue_ff[rd_ptr_ff].pad_bits;
   assign rsp_chan.last_of_run = queue_ff[rd_ptr_ff].last_of_run;
   assign rsp_chan.final_byte  = queue_ff[rd_ptr_ff].final_byte;

   // queue never overflows
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // bits not yet filled in the partial byte stay zero
   a_partial_clean: assert property (@(posedge clock) disable iff (reset)
      (partial_ff & (8'hFF >> fill_ff)) == '0)
      else $error("partial byte has bits below the fill point");

   // a flush leaves the packer empty
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_kind_ff == KIND_FLUSH) |=> (fill_ff == '0) && (partial_ff == '0))
      else $error("flush did not clear the packer");

   // an accepted word reaches the merge stage next cycle
   a_stage_follow: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted word lost before merge");

   // a padded flush byte ends its run and carries padding
   a_final_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.final_byte |-> rsp_chan.last_of_run
                                                && (rsp_chan.pad_bits != '0))
      else $error("flush byte without last mark or padding");

endmodule

// ===== bench/huffman_bit_packer_tb.sv =====
// Self-checking bench for huffman_bit_packer: a queue-fed driver, a random-stall
// receiver and a monitor that compares every byte against an in-bench packer model.
// Depends on hbp_pkg, the channel interfaces in hbp_if.sv and the top level RTL.
`timescale 1ns / 100ps

module huffman_bit_packer_tb;
   import hbp_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 4;
   localparam int QUIET_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 8;
   localparam int PRINT_LIMIT   = 40;
   localparam int ALPHABET_SIZE = 16;
   localparam int PHASE_WORDS   = 580;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   // one pending request word
   typedef struct {
      logic [KIND_W-1:0]      kind;
      logic [SYM_FIELD_W-1:0] symbol;
      logic [WORD_BITS-1:0]   code_word;
      logic [LEN_FIELD_W-1:0] code_length;
   } req_word_type;

   logic clock = 1'b0;
   logic reset;

   hbp_req_if req_bus ();
   hbp_rsp_if rsp_bus ();

   huffman_bit_packer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // packer model state
   logic [WORD_BITS-1:0]   code_mem [SYMBOL_COUNT_DEF];
   logic [LEN_FIELD_W-1:0] len_mem  [SYMBOL_COUNT_DEF] = '{default: '0};
   logic [BYTE_BITS-1:0]   acc_byte = '0;
   int                     acc_fill = 0;

   req_word_type           pending_words [$];
   rsp_type                expected_bytes [$];
   logic [SYM_FIELD_W-1:0] alphabet [ALPHABET_SIZE];

   req_word_type next_word;
   rsp_type      want;
   int           snd_idle_pct;
   int           rcv_idle_pct;
   int           mismatches = 0;
   int           quiet_cycles = 0;
   logic         stalled;

   always #(HALF_PERIOD) clock = ~clock;

   assign stalled = (quiet_cycles >= QUIET_LIMIT);

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t mismatch: %s", $time, what);
   endtask

   // advance the packer model by one accepted word and queue the bytes it yields
   function automatic void predict_word(input logic [KIND_W-1:0] k,
                                        input logic [SYM_FIELD_W-1:0] s,
                                        input logic [WORD_BITS-1:0] w,
                                        input logic [LEN_FIELD_W-1:0] l);
      rsp_type run_bytes [$];
      rsp_type b;
      int      clen;
      case (k)
         KIND_LOAD: begin
            // refuse codes longer than the table holds
            if (l <= LEN_LIMIT) begin
               code_mem[s] = w;
               len_mem[s]  = l;
            end
         end
         KIND_ENCODE: begin
            clen = len_mem[s];
            for (int j = 0; j < clen; j++) begin
               if (code_mem[s][j])
                  acc_byte[BYTE_BITS - 1 - acc_fill] = 1'b1;
               acc_fill++;
               if (acc_fill == BYTE_BITS) begin
                  b.out_byte    = acc_byte;
                  b.pad_bits    = '0;
                  b.last_of_run = 1'b0;
                  b.final_byte  = 1'b0;
                  run_bytes.push_back(b);
                  acc_byte = '0;
                  acc_fill = 0;
               end
            end
         end
         KIND_FLUSH: begin
            if (acc_fill != 0) begin
               b.out_byte    = acc_byte;
               b.pad_bits    = PAD_W'(BYTE_BITS - acc_fill);
               b.last_of_run = 1'b0;
               b.final_byte  = 1'b1;
               run_bytes.push_back(b);
            end
            acc_byte = '0;
            acc_fill = 0;
         end
         default: begin
            // unknown kind: no effect
         end
      endcase
      if (run_bytes.size() != 0) begin
         run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
         foreach (run_bytes[i])
            expected_bytes.push_back(run_bytes[i]);
      end
   endfunction

   function automatic void queue_word(input logic [KIND_W-1:0] k,
                                      input logic [SYM_FIELD_W-1:0] s,
                                      input logic [WORD_BITS-1:0] w,
                                      input logic [LEN_FIELD_W-1:0] l);
      req_word_type item;
      item.kind        = k;
      item.symbol      = s;
      item.code_word   = w;
      item.code_length = l;
      pending_words.push_back(item);
   endfunction

   // pick a fresh working alphabet and load a code for each symbol
   function automatic int reload_alphabet();
      logic [LEN_FIELD_W-1:0] l;
      foreach (alphabet[i]) begin
         alphabet[i] = SYM_FIELD_W'($urandom_range(SYMBOL_COUNT_DEF - 1));
         l = ($urandom_range(19) == 0) ? '0 : LEN_FIELD_W'($urandom_range(LEN_LIMIT, 1));
         queue_word(KIND_LOAD, alphabet[i], WORD_BITS'($urandom), l);
      end
      return ALPHABET_SIZE;
   endfunction

   // build a batch of mostly well-formed encode streams with some noise mixed in
   task automatic queue_random(input int count);
      int made;
      int pick;
      logic [SYM_FIELD_W-1:0] s;
      made = reload_alphabet();
      while (made < count) begin
         pick = $urandom_range(99);
         s    = alphabet[$urandom_range(ALPHABET_SIZE - 1)];
         if (pick < 3) begin
            made += reload_alphabet();
         end else if (pick < 80) begin
            queue_word(KIND_ENCODE, s, WORD_BITS'($urandom), LEN_FIELD_W'($urandom));
            made++;
         end else if (pick < 88) begin
            queue_word(KIND_FLUSH, SYM_FIELD_W'($urandom), WORD_BITS'($urandom),
                       LEN_FIELD_W'($urandom));
            made++;
         end else if (pick < 92) begin
            queue_word(KIND_ENCODE, SYM_FIELD_W'($urandom), WORD_BITS'($urandom),
                       LEN_FIELD_W'($urandom));
            made++;
         end else if (pick < 95) begin
            // too-long code, often aimed at a live symbol; must be refused
            if ($urandom_range(1) == 0)
               s = SYM_FIELD_W'($urandom);
            queue_word(KIND_LOAD, s, WORD_BITS'($urandom),
                       LEN_FIELD_W'($urandom_range(31, LEN_LIMIT + 1)));
         end else if (pick < 97) begin
            queue_word(KIND_UNKNOWN, SYM_FIELD_W'($urandom), WORD_BITS'($urandom),
                       LEN_FIELD_W'($urandom));
         end else begin
            queue_word(KIND_LOAD, s, WORD_BITS'($urandom),
                       LEN_FIELD_W'($urandom_range(LEN_LIMIT)));
            made++;
         end
      end
   endtask

   // hold the sender until every queued word is taken and every byte has come back;
   // sample at the falling edge so the clocked blocks have settled
   task automatic drain_all();
      while ((pending_words.size() != 0 || req_bus.valid) && !stalled)
         @(negedge clock);
      while (expected_bytes.size() != 0 && !stalled)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // request driver: present the next queued word, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_word(req_bus.kind, req_bus.symbol, req_bus.code_word,
                         req_bus.code_length);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               next_word = pending_words.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.kind        <= next_word.kind;
               req_bus.symbol      <= next_word.symbol;
               req_bus.code_word   <= next_word.code_word;
               req_bus.code_length <= next_word.code_length;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: stall at random
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // result monitor: compare each accepted byte with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bytes.size() == 0) begin
            flag_mismatch($sformatf("byte %h arrived with none expected", rsp_bus.out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_bus.out_byte !== want.out_byte)
               flag_mismatch($sformatf("out_byte %h, want %h", rsp_bus.out_byte,
                                       want.out_byte));
            if (rsp_bus.pad_bits !== want.pad_bits)
               flag_mismatch($sformatf("pad_bits %0d, want %0d", rsp_bus.pad_bits,
                                       want.pad_bits));
            if (rsp_bus.last_of_run !== want.last_of_run)
               flag_mismatch($sformatf("last_of_run %b, want %b", rsp_bus.last_of_run,
                                       want.last_of_run));
            if (rsp_bus.final_byte !== want.final_byte)
               flag_mismatch($sformatf("final_byte %b, want %b", rsp_bus.final_byte,
                                       want.final_byte));
         end
      end
   end

   // watchdog: count cycles in which neither channel moves a word, end the run at the limit
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_LOAD;
      req_bus.symbol      = '0;
      req_bus.code_word   = '0;
      req_bus.code_length = '0;
      rsp_bus.ready       = 1'b0;
      snd_idle_pct        = 15;
      rcv_idle_pct        = 85;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, empty flush, extremes, refused and zero-length codes
      queue_word(KIND_ENCODE, 8'd0,   16'h0000, 5'd0);
      queue_word(KIND_FLUSH,  8'd0,   16'h0000, 5'd0);
      queue_word(KIND_LOAD,   8'd0,   16'hFFFF, 5'd16);
      queue_word(KIND_LOAD,   8'd255, 16'h0001, 5'd1);
      queue_word(KIND_LOAD,   8'd1,   16'h0000, 5'd16);
      queue_word(KIND_LOAD,   8'd2,   16'h0055, 5'd7);
      queue_word(KIND_LOAD,   8'd3,   16'hABCD, 5'd0);
      queue_word(KIND_LOAD,   8'd4,   16'h1234, 5'd17);
      queue_word(KIND_LOAD,   8'd0,   16'h0000, 5'd31);
      queue_word(KIND_ENCODE, 8'd255, 16'hFFFF, 5'd31);
      queue_word(KIND_ENCODE, 8'd0,   16'h0000, 5'd0);
      queue_word(KIND_ENCODE, 8'd2,   16'h0000, 5'd0);
      queue_word(KIND_ENCODE, 8'd3,   16'h0000, 5'd0);
      queue_word(KIND_ENCODE, 8'd4,   16'h0000, 5'd0);
      queue_word(KIND_UNKNOWN, 8'hFF, 16'hFFFF, 5'd31);
      queue_word(KIND_FLUSH,  8'hFF,  16'hFFFF, 5'd31);
      queue_word(KIND_ENCODE, 8'd1,   16'h0000, 5'd0);
      queue_word(KIND_ENCODE, 8'd1,   16'h0000, 5'd0);
      queue_word(KIND_FLUSH,  8'd0,   16'h0000, 5'd0);
      queue_word(KIND_FLUSH,  8'd0,   16'h0000, 5'd0);
      queue_word(KIND_ENCODE, 8'd2,   16'h0000, 5'd0);
      queue_word(KIND_FLUSH,  8'd0,   16'h0000, 5'd0);
      queue_word(KIND_ENCODE, 8'd255, 16'h0000, 5'd0);
      queue_word(KIND_FLUSH,  8'd0,   16'h0000, 5'd0);

      // busy sender, slow receiver
      queue_random(PHASE_WORDS);
      drain_all();

      // slow sender, busy receiver
      snd_idle_pct = 85;
      rcv_idle_pct = 15;
      queue_random(PHASE_WORDS);
      drain_all();

      // full rate on both sides
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      queue_random(PHASE_WORDS);
      drain_all();

      if (expected_bytes.size() != 0)
         flag_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      if (!stalled && mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
